>>> rtl/core/dbpa_pkg.sv
package dbpa_pkg;

    // defaults for the top level parameters
    localparam int NUM_SEGMENTS_DEF = 4;
    localparam int SEG_PAGES_DEF    = 1024;
    localparam int PFN_BITS_DEF     = 24;

    // fixed register file and field widths
    localparam int REG_SEGS      = 4;
    localparam int SIDX_W        = 2;
    localparam int CSEG_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 24;
    localparam int PAGE_W        = 24;
    localparam int SEGP_W        = 11;
    localparam int WORD_W        = 32;
    localparam int PAGES_REG_MAX = 2047;

    localparam logic [31:0] ENTRY_KEEP  = 32'hff;
    localparam int          ENTRY_SHIFT = 8;

    // register index bit 0 selects page count over start frame
    localparam logic CFG_SEL_PAGES = 1'b1;

    localparam logic [2:0] OP_LOAD_KERNEL = 3'd0;
    localparam logic [2:0] OP_LOAD_BOOT   = 3'd1;
    localparam logic [2:0] OP_MARK        = 3'd2;
    localparam logic [2:0] OP_QUERY       = 3'd3;
    localparam logic [2:0] OP_ALLOC       = 3'd4;
    localparam logic [2:0] OP_RELOC       = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MARK_FAIL = 2'd1;
    localparam logic [1:0] ST_NO_FREE   = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  word_address;
        logic [31:0] word_data;
        logic [23:0] page_number;
        logic [31:0] old_entry;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        kernel_free;
        logic        boot_free;
        logic [23:0] result_page;
        logic        moved;
        logic [31:0] new_entry;
    } t_result;

    // one segment as the range compare unit sees it
    typedef struct packed {
        logic              nz;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W:0]   stop;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_FIND,
        S_PREAD,
        S_PEVAL,
        S_SCAN,
        S_OVL,
        S_WREAD,
        S_WEVAL,
        S_SFIND,
        S_SREAD,
        S_SEVAL
    } t_state;

endpackage

>>> rtl/core/dbpa_ram.sv
module dbpa_ram #(
    parameter int WIDTH = dbpa_pkg::WORD_W,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/dbpa_seg_match.sv
module dbpa_seg_match #(
    parameter int SEG_PAGES = dbpa_pkg::SEG_PAGES_DEF,
    localparam int LEN_MAX = (SEG_PAGES < dbpa_pkg::PAGES_REG_MAX) ? SEG_PAGES
                                                                  : dbpa_pkg::PAGES_REG_MAX,
    localparam int OFF_W = $clog2(LEN_MAX)
) (
    input  dbpa_pkg::t_seg [dbpa_pkg::REG_SEGS-1:0] i_segs,
    input  logic [dbpa_pkg::SIDX_W-1:0]             i_idx,
    input  logic [dbpa_pkg::PAGE_W-1:0]             i_lo,
    input  logic [dbpa_pkg::PAGE_W-1:0]             i_hi,
    output logic                                    o_hit,
    output logic [OFF_W-1:0]                        o_off
);

    dbpa_pkg::t_seg sel;

    // range [lo, hi] touches the selected segment; lo == hi is a point lookup
    always_comb begin
        sel   = i_segs[i_idx];
        o_hit = sel.nz && ({1'b0, i_lo} < sel.stop) && (i_hi >= sel.start);
        o_off = OFF_W'(i_lo - sel.start);
    end

endmodule

>>> rtl/core/dual_bitmap_page_allocator_core.sv
// Dual bitmap page frame allocator.
// Software sets up to four segments through the write port (even index: first
// frame, odd index: page count), then loads the kernel and boot bitmaps one
// word at a time and issues mark, query, allocate and relocate commands.
// A command is taken when start is high and busy is low; every command gives
// exactly one word on o_result, flagged by o_valid for a single cycle. The
// receiver has no way to hold it off, and the next command may start in the
// cycle the result is shown.
// Loads and unused codes finish in the load state; mark and query try one
// segment at a time in the range compare unit, then do one bitmap read.
// Allocation walks the cursor one 32-page map word at a time (scan, read,
// evaluate), with an overlap check against each lower segment in segment s;
// a word shared with a lower segment is walked page by page, each page found
// again in the range compare unit and then read. There is a single range
// compare unit and a single map read port; one command is in flight at a time.
// Reset clears the segment registers and the allocation cursor; the bitmaps
// hold garbage until loaded.
module dual_bitmap_page_allocator_core #(
    parameter int NUM_SEGMENTS = dbpa_pkg::NUM_SEGMENTS_DEF,
    parameter int SEG_PAGES    = dbpa_pkg::SEG_PAGES_DEF,
    parameter int PFN_BITS     = dbpa_pkg::PFN_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  dbpa_pkg::t_item                  i_item,
    output logic                             o_valid,
    output dbpa_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [dbpa_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [dbpa_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int USED_SEGS = (NUM_SEGMENTS < dbpa_pkg::REG_SEGS) ? NUM_SEGMENTS
                                                                   : dbpa_pkg::REG_SEGS;
    localparam int WPS       = (SEG_PAGES + 31) / 32;
    localparam int MAP_WORDS = USED_SEGS * WPS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LEN_MAX   = (SEG_PAGES < dbpa_pkg::PAGES_REG_MAX) ? SEG_PAGES
                                                                     : dbpa_pkg::PAGES_REG_MAX;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);
    localparam int OFF_W     = $clog2(LEN_MAX);
    localparam int PW        = dbpa_pkg::PAGE_W;
    localparam int SW        = dbpa_pkg::SIDX_W;
    localparam int CW        = dbpa_pkg::CSEG_W;
    localparam logic [PW-1:0] PFN_MASK  = PW'((33'd1 << PFN_BITS) - 33'd1);
    localparam logic [PW:0]   PFN_SPACE = (PW + 1)'(33'd1 << PFN_BITS);

    // segment registers and derived ranges
    logic [PW-1:0]                   r_start [dbpa_pkg::REG_SEGS];
    logic [dbpa_pkg::SEGP_W-1:0]     r_pages [dbpa_pkg::REG_SEGS];
    dbpa_pkg::t_seg [dbpa_pkg::REG_SEGS-1:0] r_seg_info, n_seg_info;
    logic [LEN_W-1:0]                r_len [dbpa_pkg::REG_SEGS];
    logic [LEN_W-1:0]                n_len [dbpa_pkg::REG_SEGS];
    logic [PW:0]                     d_room [dbpa_pkg::REG_SEGS];
    logic [PW:0]                     d_cnt [dbpa_pkg::REG_SEGS];

    // sequencer
    dbpa_pkg::t_state  r_state, n_state;
    dbpa_pkg::t_item   r_item;
    dbpa_pkg::t_result r_out, n_out;
    logic              r_valid, n_valid;
    logic [SW-1:0]     r_seg, n_seg;
    logic [SW-1:0]     r_found, n_found;
    logic [SW-1:0]     r_chk, n_chk;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [CW-1:0]     r_scan_seg, n_scan_seg;
    logic [LEN_W-1:0]  r_scan_page, n_scan_page;
    logic [LEN_W-1:0]  r_chunk_end, n_chunk_end;
    logic [PW-1:0]     r_pa, n_pa;
    logic [PW-1:0]     r_pb, n_pb;
    logic [CW-1:0]     r_cur_seg, n_cur_seg;
    logic [LEN_W-1:0]  r_cur_page, n_cur_page;

    // range compare unit
    logic [SW-1:0]     m_idx;
    logic [PW-1:0]     m_lo, m_hi;
    logic              m_hit;
    logic [OFF_W-1:0]  m_off;

    // map memories
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic [31:0]       ram_wdata;
    logic              k_we, b_we;
    logic [31:0]       k_q, b_q;

    // helpers
    logic              accept;
    logic [SW-1:0]     sidx;
    logic [LEN_W-1:0]  sc_n;
    logic [PW-1:0]     sc_start;
    logic [31:0]       sc_last;
    logic [AW-1:0]     pt_addr, sc_addr;
    logic [4:0]        pt_bit;
    logic [31:0]       w_free;
    logic              w_any;
    logic [4:0]        w_bit;
    logic [LEN_W-1:0]  w_off;
    logic [PW-1:0]     w_page;

    function automatic logic [AW-1:0] f_waddr(input logic [SW-1:0] s,
                                              input logic [OFF_W-1:0] off);
        return AW'(32'(s) * WPS + (32'(off) >> 5));
    endfunction

    function automatic dbpa_pkg::t_result f_alloc_res(input dbpa_pkg::t_item it,
                                                      input logic [PW-1:0] pg);
        dbpa_pkg::t_result res;
        res             = '0;
        res.status      = dbpa_pkg::ST_OK;
        res.result_page = pg;
        if (it.op == dbpa_pkg::OP_RELOC) begin
            res.moved     = 1'b1;
            res.new_entry = (it.old_entry & dbpa_pkg::ENTRY_KEEP)
                          | (32'(pg) << dbpa_pkg::ENTRY_SHIFT);
        end
        return res;
    endfunction

    function automatic dbpa_pkg::t_result f_fail_res(input dbpa_pkg::t_item it);
        dbpa_pkg::t_result res;
        res        = '0;
        res.status = dbpa_pkg::ST_NO_FREE;
        if (it.op == dbpa_pkg::OP_RELOC) begin
            res.new_entry = it.old_entry;
        end
        return res;
    endfunction

    function automatic dbpa_pkg::t_result f_keep_res(input dbpa_pkg::t_item it);
        dbpa_pkg::t_result res;
        res             = '0;
        res.result_page = it.page_number;
        res.new_entry   = it.old_entry;
        return res;
    endfunction

    assign accept = start && !busy;
    assign busy   = (r_state != dbpa_pkg::S_IDLE);

    // clamp each segment to the cap and to the top of the frame space
    always_comb begin
        for (int s = 0; s < dbpa_pkg::REG_SEGS; s++) begin
            d_room[s] = PFN_SPACE - {1'b0, r_start[s]};
            d_cnt[s]  = ({14'd0, r_pages[s]} > (PW + 1)'(LEN_MAX)) ? (PW + 1)'(LEN_MAX)
                                                                  : {14'd0, r_pages[s]};
            if (d_cnt[s] > d_room[s]) begin
                d_cnt[s] = d_room[s];
            end
            n_len[s]            = LEN_W'(d_cnt[s]);
            n_seg_info[s].nz    = (d_cnt[s] != '0);
            n_seg_info[s].start = r_start[s];
            n_seg_info[s].stop  = {1'b0, r_start[s]} + d_cnt[s];
        end
    end

    dbpa_seg_match #(
        .SEG_PAGES(SEG_PAGES)
    ) u_match (
        .i_segs(r_seg_info),
        .i_idx (m_idx),
        .i_lo  (m_lo),
        .i_hi  (m_hi),
        .o_hit (m_hit),
        .o_off (m_off)
    );

    dbpa_ram #(
        .WIDTH(32),
        .DEPTH(MAP_WORDS)
    ) u_kernel_map (
        .i_clk  (i_clk),
        .i_we   (k_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(k_q)
    );

    dbpa_ram #(
        .WIDTH(32),
        .DEPTH(MAP_WORDS)
    ) u_boot_map (
        .i_clk  (i_clk),
        .i_we   (b_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(b_q)
    );

    always_comb begin
        sidx     = r_scan_seg[SW-1:0];
        sc_n     = r_len[sidx];
        sc_start = r_start[sidx];
        // last page of the current map word, bounded by the segment end
        sc_last  = 32'(r_scan_page) | 32'd31;
        if (sc_last > 32'(sc_n) - 32'd1) begin
            sc_last = 32'(sc_n) - 32'd1;
        end
        pt_addr = f_waddr(r_found, r_off);
        sc_addr = f_waddr(sidx, OFF_W'(r_scan_page));
        pt_bit  = 5'(r_off);

        for (int i = 0; i < 32; i++) begin
            w_free[i] = !(k_q[i] | b_q[i]) && (5'(i) >= 5'(r_scan_page))
                        && (5'(i) <= 5'(r_chunk_end));
        end
        w_any = 1'b0;
        w_bit = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w_free[i]) begin
                w_any = 1'b1;
                w_bit = 5'(i);
            end
        end
        w_off  = LEN_W'((32'(r_scan_page) & ~32'd31) | 32'(w_bit));
        w_page = sc_start + PW'(w_off);
    end

    always_comb begin
        case (r_state)
            dbpa_pkg::S_OVL: begin
                m_idx = r_chk;
                m_lo  = r_pa;
                m_hi  = r_pb;
            end
            dbpa_pkg::S_SFIND: begin
                m_idx = r_seg;
                m_lo  = r_pa;
                m_hi  = r_pa;
            end
            default: begin
                m_idx = r_seg;
                m_lo  = r_item.page_number;
                m_hi  = r_item.page_number;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_valid     = 1'b0;
        n_seg       = r_seg;
        n_found     = r_found;
        n_chk       = r_chk;
        n_off       = r_off;
        n_scan_seg  = r_scan_seg;
        n_scan_page = r_scan_page;
        n_chunk_end = r_chunk_end;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_cur_seg   = r_cur_seg;
        n_cur_page  = r_cur_page;
        ram_raddr   = pt_addr;
        ram_waddr   = pt_addr;
        ram_wdata   = b_q | (32'd1 << pt_bit);
        k_we        = 1'b0;
        b_we        = 1'b0;

        case (r_state)
            dbpa_pkg::S_IDLE: begin
                if (accept) begin
                    n_seg       = '0;
                    n_scan_seg  = r_cur_seg;
                    n_scan_page = r_cur_page;
                    case (i_item.op)
                        dbpa_pkg::OP_MARK, dbpa_pkg::OP_QUERY, dbpa_pkg::OP_RELOC: begin
                            n_state = dbpa_pkg::S_FIND;
                        end
                        dbpa_pkg::OP_ALLOC: begin
                            n_state = dbpa_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = dbpa_pkg::S_LOAD;
                        end
                    endcase
                end
            end

            dbpa_pkg::S_LOAD: begin
                ram_waddr = AW'(r_item.word_address);
                ram_wdata = r_item.word_data;
                if (32'(r_item.word_address) < MAP_WORDS) begin
                    k_we = (r_item.op == dbpa_pkg::OP_LOAD_KERNEL);
                    b_we = (r_item.op == dbpa_pkg::OP_LOAD_BOOT);
                end
                n_out   = '0;
                n_valid = 1'b1;
                n_state = dbpa_pkg::S_IDLE;
            end

            dbpa_pkg::S_FIND: begin
                if (m_hit) begin
                    n_found = r_seg;
                    n_off   = m_off;
                    n_state = dbpa_pkg::S_PREAD;
                end else if (r_seg == SW'(USED_SEGS - 1)) begin
                    // page lies in no segment
                    n_out = '0;
                    case (r_item.op)
                        dbpa_pkg::OP_MARK: begin
                            n_out.status = dbpa_pkg::ST_MARK_FAIL;
                        end
                        dbpa_pkg::OP_QUERY: begin
                            n_out.kernel_free = 1'b1;
                            n_out.boot_free   = 1'b1;
                        end
                        default: begin
                            n_out = f_keep_res(r_item);
                        end
                    endcase
                    n_valid = 1'b1;
                    n_state = dbpa_pkg::S_IDLE;
                end else begin
                    n_seg = r_seg + SW'(1);
                end
            end

            dbpa_pkg::S_PREAD: begin
                ram_raddr = pt_addr;
                n_state   = dbpa_pkg::S_PEVAL;
            end

            dbpa_pkg::S_PEVAL: begin
                n_out = '0;
                case (r_item.op)
                    dbpa_pkg::OP_MARK: begin
                        if (b_q[pt_bit]) begin
                            n_out.status = dbpa_pkg::ST_MARK_FAIL;
                        end else begin
                            b_we = 1'b1;
                        end
                        n_valid = 1'b1;
                        n_state = dbpa_pkg::S_IDLE;
                    end
                    dbpa_pkg::OP_QUERY: begin
                        n_out.kernel_free = !k_q[pt_bit];
                        n_out.boot_free   = !b_q[pt_bit];
                        n_valid           = 1'b1;
                        n_state           = dbpa_pkg::S_IDLE;
                    end
                    default: begin
                        if (!k_q[pt_bit]) begin
                            n_out   = f_keep_res(r_item);
                            n_valid = 1'b1;
                            n_state = dbpa_pkg::S_IDLE;
                        end else begin
                            n_state = dbpa_pkg::S_SCAN;
                        end
                    end
                endcase
            end

            dbpa_pkg::S_SCAN: begin
                if (32'(r_scan_seg) >= USED_SEGS) begin
                    n_out   = f_fail_res(r_item);
                    n_valid = 1'b1;
                    n_state = dbpa_pkg::S_IDLE;
                end else if (r_scan_page >= sc_n) begin
                    n_scan_seg  = r_scan_seg + CW'(1);
                    n_scan_page = '0;
                end else begin
                    n_chunk_end = LEN_W'(sc_last);
                    n_pa        = sc_start + PW'(r_scan_page);
                    n_pb        = sc_start + PW'(sc_last);
                    n_chk       = '0;
                    n_seg       = '0;
                    n_state     = (r_scan_seg == '0) ? dbpa_pkg::S_WREAD : dbpa_pkg::S_OVL;
                end
            end

            dbpa_pkg::S_OVL: begin
                // a lower segment sharing these pages owns them: go page by page
                if (m_hit) begin
                    n_seg   = '0;
                    n_state = dbpa_pkg::S_SFIND;
                end else if (({1'b0, r_chk} + CW'(1)) == r_scan_seg) begin
                    n_state = dbpa_pkg::S_WREAD;
                end else begin
                    n_chk = r_chk + SW'(1);
                end
            end

            dbpa_pkg::S_WREAD: begin
                ram_raddr = sc_addr;
                n_state   = dbpa_pkg::S_WEVAL;
            end

            dbpa_pkg::S_WEVAL: begin
                ram_waddr = sc_addr;
                ram_wdata = b_q | (32'd1 << w_bit);
                if (w_any) begin
                    b_we = 1'b1;
                    if (32'(w_off) + 32'd1 < 32'(sc_n)) begin
                        n_cur_seg  = r_scan_seg;
                        n_cur_page = w_off + LEN_W'(1);
                    end else begin
                        n_cur_seg  = r_scan_seg + CW'(1);
                        n_cur_page = '0;
                    end
                    n_out   = f_alloc_res(r_item, w_page);
                    n_valid = 1'b1;
                    n_state = dbpa_pkg::S_IDLE;
                end else begin
                    n_scan_page = r_chunk_end + LEN_W'(1);
                    n_state     = dbpa_pkg::S_SCAN;
                end
            end

            dbpa_pkg::S_SFIND: begin
                if (m_hit) begin
                    n_found = r_seg;
                    n_off   = m_off;
                    n_state = dbpa_pkg::S_SREAD;
                end else begin
                    n_seg = r_seg + SW'(1);
                end
            end

            dbpa_pkg::S_SREAD: begin
                ram_raddr = pt_addr;
                n_state   = dbpa_pkg::S_SEVAL;
            end

            dbpa_pkg::S_SEVAL: begin
                if (!k_q[pt_bit] && !b_q[pt_bit]) begin
                    b_we = 1'b1;
                    if (32'(r_scan_page) + 32'd1 < 32'(sc_n)) begin
                        n_cur_seg  = r_scan_seg;
                        n_cur_page = r_scan_page + LEN_W'(1);
                    end else begin
                        n_cur_seg  = r_scan_seg + CW'(1);
                        n_cur_page = '0;
                    end
                    n_out   = f_alloc_res(r_item, r_pa);
                    n_valid = 1'b1;
                    n_state = dbpa_pkg::S_IDLE;
                end else if (r_scan_page == r_chunk_end) begin
                    n_scan_page = r_chunk_end + LEN_W'(1);
                    n_state     = dbpa_pkg::S_SCAN;
                end else begin
                    n_scan_page = r_scan_page + LEN_W'(1);
                    n_pa        = r_pa + PW'(1);
                    n_seg       = '0;
                    n_state     = dbpa_pkg::S_SFIND;
                end
            end

            default: begin
                n_state = dbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dbpa_pkg::S_IDLE;
            r_valid    <= 1'b0;
            r_cur_seg  <= '0;
            r_cur_page <= '0;
            for (int s = 0; s < dbpa_pkg::REG_SEGS; s++) begin
                r_start[s] <= '0;
                r_pages[s] <= '0;
                r_len[s]   <= '0;
            end
            r_seg_info <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_cur_seg  <= n_cur_seg;
            r_cur_page <= n_cur_page;
            r_seg_info <= n_seg_info;
            for (int s = 0; s < dbpa_pkg::REG_SEGS; s++) begin
                r_len[s] <= n_len[s];
            end
            if (i_cfg_we) begin
                if (i_cfg_addr[0] == dbpa_pkg::CFG_SEL_PAGES) begin
                    r_pages[i_cfg_addr[SW:1]] <= i_cfg_wdata[dbpa_pkg::SEGP_W-1:0];
                end else begin
                    r_start[i_cfg_addr[SW:1]] <= i_cfg_wdata & PFN_MASK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_out       <= n_out;
        r_seg       <= n_seg;
        r_found     <= n_found;
        r_chk       <= n_chk;
        r_off       <= n_off;
        r_scan_seg  <= n_scan_seg;
        r_scan_page <= n_scan_page;
        r_chunk_end <= n_chunk_end;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    // a word only comes out of a command that was in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a command in progress");

    // the result is shown once the sequencer is back at idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while still busy");

    // the cursor never runs past the segment after the last one
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur_seg) <= USED_SEGS)
        else $error("cursor segment out of range");

    // work only starts on a taken command
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");

endmodule
